// ----- hdl/fatlb_pkg.sv -----
// Shared types and constants for the fully associative TLB with LRU order.
// No dependencies; every other file imports this package.
package fatlb_pkg;

  localparam int LINES_DEF  = 128;
  localparam int CMD_W      = 2;
  localparam int TAG_W      = 36;
  localparam int PAGE_W     = 32;
  localparam int OFFSET_W   = 12;
  localparam int LINE_OUT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_REFILL    = 2'd1,
    CMD_FLUSH     = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [PAGE_W-1:0] page;
  } entry_t;

  typedef struct packed {
    logic shift_en;
    logic flush;
  } cell_ctl_t;

endpackage

// ----- hdl/fatlb_req_if.sv -----
// Request channel of the TLB: command, virtual page, offset and refill page.
// Depends on fatlb_pkg.
interface fatlb_req_if;
  import fatlb_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TAG_W-1:0]    virtual_page;
  logic [OFFSET_W-1:0] byte_offset;
  logic [PAGE_W-1:0]   fill_phys_page;

  modport source (output valid, command, virtual_page, byte_offset, fill_phys_page,
                  input ready);
  modport sink   (input valid, command, virtual_page, byte_offset, fill_phys_page,
                  output ready);
endinterface

// ----- hdl/fatlb_rsp_if.sv -----
// Response channel of the TLB: hit flag, physical page, offset and line.
// Depends on fatlb_pkg.
interface fatlb_rsp_if;
  import fatlb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [PAGE_W-1:0]     phys_page;
  logic [OFFSET_W-1:0]   out_offset;
  logic [LINE_OUT_W-1:0] line_used;

  modport source (output valid, hit, phys_page, out_offset, line_used, input ready);
  modport sink   (input valid, hit, phys_page, out_offset, line_used, output ready);
endinterface

// ----- hdl/fully_assoc_tlb_lru_unit.sv -----
// Top level of the fully associative TLB with LRU replacement.
// Uses fatlb_pkg, fatlb_req_if, fatlb_rsp_if, fatlb_cell and fatlb_pick.
//
//   channel | dir | transfer payload
//   req     | in  | command, virtual_page, byte_offset, fill_phys_page
//   rsp     | out | hit, phys_page, out_offset, line_used
//
// Every request passes through four steps: take, tag compare in every cell, pick of the
// most recent match, then update of the cell row and the response register.
// The cell row shifts toward the least recent end by one position per cell, in the update step.
// Reset sets the row to line indices in ascending order, all invalid.
// A response waiting on rsp does not block the next request from entering;
// the update step holds until the response register is free.
module fully_assoc_tlb_lru_unit #(
  parameter int LINES = fatlb_pkg::LINES_DEF
) (
  input logic        clk,
  input logic        rst,
  fatlb_req_if.sink   req,
  fatlb_rsp_if.source rsp
);
  import fatlb_pkg::*;

  localparam int IDX_W = $clog2(LINES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_SELECT = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0]    cmd_q;
  logic [TAG_W-1:0]    key_q;
  logic [OFFSET_W-1:0] off_q;
  logic [PAGE_W-1:0]   fill_q;

  logic [LINES-1:0] match_row;
  logic [LINES-1:0] match_q;
  logic [LINES-1:0] onehot;
  logic [LINES-1:0] onehot_q;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_q;
  logic             any;
  logic             hit_q;

  logic [IDX_W-1:0]  idx_row      [LINES];
  entry_t            ent_row      [LINES];
  logic [PAGE_W-1:0] sel_page_row [LINES];
  logic [IDX_W-1:0]  sel_idx_row  [LINES];

  logic [PAGE_W-1:0] sel_page;
  logic [IDX_W-1:0]  sel_idx;
  logic [IDX_W-1:0]  shift_from;
  logic [IDX_W-1:0]  inj_idx;
  entry_t            inj_ent;
  cell_ctl_t         ctl;

  logic                  accept;
  logic                  commit;
  logic                  is_translate;
  logic                  is_refill;
  logic                  is_flush;
  logic                  rsp_valid;
  logic                  hit_out;
  logic [PAGE_W-1:0]     phys_out;
  logic [IDX_W-1:0]      line_idx;
  logic                  rsp_hit;
  logic [PAGE_W-1:0]     rsp_page;
  logic [OFFSET_W-1:0]   rsp_off;
  logic [LINE_OUT_W-1:0] rsp_line;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign commit       = (state == S_UPDATE) && (!rsp_valid || rsp.ready);
  assign is_translate = (cmd_q == CMD_TRANSLATE);
  assign is_refill    = (cmd_q == CMD_REFILL);
  assign is_flush     = (cmd_q == CMD_FLUSH);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_MATCH;
      S_MATCH:  state_next = S_SELECT;
      S_SELECT: state_next = S_UPDATE;
      S_UPDATE: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.command;
      key_q  <= req.virtual_page;
      off_q  <= req.byte_offset;
      fill_q <= req.fill_phys_page;
    end
    if (state == S_MATCH) begin
      match_q <= match_row;
    end
    if (state == S_SELECT) begin
      onehot_q <= onehot;
      pos_q    <= pos;
      hit_q    <= any;
    end
    if (commit) begin
      rsp_hit  <= hit_out;
      rsp_page <= phys_out;
      rsp_off  <= off_q;
      rsp_line <= LINE_OUT_W'(line_idx);
    end
  end

  fatlb_pick #(.LINES(LINES)) u_pick (
    .match  (match_q),
    .onehot (onehot),
    .pos    (pos),
    .any    (any)
  );

  always_comb begin
    sel_page = '0;
    sel_idx  = '0;
    for (int p = 0; p < LINES; p++) begin
      sel_page = sel_page | sel_page_row[p];
      sel_idx  = sel_idx | sel_idx_row[p];
    end
  end

  always_comb begin
    shift_from    = is_refill ? '0 : pos_q;
    ctl.shift_en  = commit && ((is_translate && hit_q) || is_refill);
    ctl.flush     = commit && is_flush;
    inj_idx       = is_refill ? idx_row[0] : sel_idx;
    inj_ent.valid = 1'b1;
    inj_ent.tag   = key_q;
    inj_ent.page  = is_refill ? fill_q : sel_page;
    hit_out       = is_translate && hit_q;
    phys_out      = '0;
    line_idx      = '0;
    if (is_refill) begin
      phys_out = fill_q;
      line_idx = idx_row[0];
    end else if (hit_out) begin
      phys_out = sel_page;
      line_idx = sel_idx;
    end
  end

  for (genvar p = 0; p < LINES; p++) begin : g_row
    logic [IDX_W-1:0] up_idx;
    entry_t           up_ent;

    if (p == LINES - 1) begin : g_top
      assign up_idx = inj_idx;
      assign up_ent = inj_ent;
    end else begin : g_mid
      assign up_idx = idx_row[p+1];
      assign up_ent = ent_row[p+1];
    end

    fatlb_cell #(.LINES(LINES), .POS(p)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .shift_from (shift_from),
      .key        (key_q),
      .sel        (onehot_q[p]),
      .up_idx     (up_idx),
      .up_ent     (up_ent),
      .idx        (idx_row[p]),
      .ent        (ent_row[p]),
      .match      (match_row[p]),
      .sel_page   (sel_page_row[p]),
      .sel_idx    (sel_idx_row[p])
    );
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.phys_page  = rsp_page;
  assign rsp.out_offset = rsp_off;
  assign rsp.line_used  = rsp_line;

endmodule

// ----- hdl/fatlb_cell.sv -----
// One recency position of the TLB: line index, tag, page and valid bit.
// Takes its neighbor's entry on a shift; depends on fatlb_pkg.
module fatlb_cell #(
  parameter int LINES = 128,
  parameter int POS   = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fatlb_pkg::cell_ctl_t       ctl,
  input  logic [$clog2(LINES)-1:0]   shift_from,
  input  logic [fatlb_pkg::TAG_W-1:0] key,
  input  logic                       sel,
  input  logic [$clog2(LINES)-1:0]   up_idx,
  input  fatlb_pkg::entry_t          up_ent,
  output logic [$clog2(LINES)-1:0]   idx,
  output fatlb_pkg::entry_t          ent,
  output logic                       match,
  output logic [fatlb_pkg::PAGE_W-1:0] sel_page,
  output logic [$clog2(LINES)-1:0]   sel_idx
);
  import fatlb_pkg::*;

  localparam int IDX_W = $clog2(LINES);

  logic take;

  assign take = ctl.shift_en && (IDX_W'(POS) >= shift_from);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= IDX_W'(POS);
      ent.valid <= 1'b0;
    end else if (take) begin
      idx <= up_idx;
      ent <= up_ent;
    end else if (ctl.flush) begin
      ent.valid <= 1'b0;
    end
  end

  assign match    = ent.valid && (ent.tag == key);
  assign sel_page = sel ? ent.page : '0;
  assign sel_idx  = sel ? idx : '0;

endmodule

// ----- hdl/fatlb_pick.sv -----
// Picks the most recent matching position out of the row's match vector.
// Gives a one-hot select and its position; depends on fatlb_pkg only by style.
module fatlb_pick #(
  parameter int LINES = 128
) (
  input  logic [LINES-1:0]         match,
  output logic [LINES-1:0]         onehot,
  output logic [$clog2(LINES)-1:0] pos,
  output logic                     any
);
  import fatlb_pkg::*;

  localparam int IDX_W = $clog2(LINES);

  logic [LINES-1:0] rev;
  logic [LINES-1:0] iso;
  logic [LINES-1:0] enc_mask [IDX_W];

  for (genvar b = 0; b < IDX_W; b++) begin : g_mask
    for (genvar p = 0; p < LINES; p++) begin : g_bit
      assign enc_mask[b][p] = 1'((p >> b) & 1);
    end
  end

  always_comb begin
    for (int p = 0; p < LINES; p++) begin
      rev[p] = match[LINES-1-p];
    end
    iso = rev & (~rev + LINES'(1));
    for (int p = 0; p < LINES; p++) begin
      onehot[p] = iso[LINES-1-p];
    end
    for (int b = 0; b < IDX_W; b++) begin
      pos[b] = |(onehot & enc_mask[b]);
    end
  end

  assign any = |match;

endmodule

// ----- sim/fatlb_lookup_checker.sv -----
// Passive checker for the fully associative TLB: watches the req and rsp channels,
// keeps its own copy of tags, pages, valid bits and LRU order, and compares each transfer.
// Depends on fatlb_pkg, fatlb_req_if and fatlb_rsp_if.
module fatlb_lookup_checker #(
  parameter int LINES = fatlb_pkg::LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fatlb_req_if        req,
  fatlb_rsp_if        rsp,
  output int          mismatches,
  output int          outstanding
);
  import fatlb_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [PAGE_W-1:0]     phys_page;
    logic [OFFSET_W-1:0]   offset;
    logic [LINE_OUT_W-1:0] line;
  } answer_t;

  logic [TAG_W-1:0]  tag_mem    [LINES];
  logic [PAGE_W-1:0] page_mem   [LINES];
  logic              line_valid [LINES];
  int                lru_order  [LINES];
  answer_t           expected_answers [$];

  // Move the line at order position pos to the most recent end.
  function automatic void promote(int pos);
    int line_idx;
    line_idx = lru_order[pos];
    for (int p = pos; p < LINES - 1; p++) lru_order[p] = lru_order[p + 1];
    lru_order[LINES - 1] = line_idx;
  endfunction

  function automatic answer_t predict_lookup(logic [CMD_W-1:0] command,
                                             logic [TAG_W-1:0] vpage,
                                             logic [OFFSET_W-1:0] offset,
                                             logic [PAGE_W-1:0] fill);
    answer_t ans;
    int      line_idx;
    ans = '0;
    ans.offset = offset;
    case (command)
      CMD_TRANSLATE: begin
        for (int pos = LINES - 1; pos >= 0; pos--) begin
          line_idx = lru_order[pos];
          if (line_valid[line_idx] && tag_mem[line_idx] == vpage) begin
            ans.hit = 1'b1;
            ans.phys_page = page_mem[line_idx];
            ans.line = line_idx[LINE_OUT_W-1:0];
            promote(pos);
            break;
          end
        end
      end
      CMD_REFILL: begin
        line_idx = lru_order[0];
        tag_mem[line_idx] = vpage;
        page_mem[line_idx] = fill;
        line_valid[line_idx] = 1'b1;
        promote(0);
        ans.phys_page = fill;
        ans.line = line_idx[LINE_OUT_W-1:0];
      end
      CMD_FLUSH: begin
        for (int i = 0; i < LINES; i++) line_valid[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : track
    answer_t want;
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        tag_mem[i] = '0;
        page_mem[i] = '0;
        line_valid[i] = 1'b0;
        lru_order[i] = i;
      end
      expected_answers.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_answers.size() == 0) begin
          $error("rsp transfer with no request pending");
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
            mismatches++;
          end
          if (rsp.phys_page !== want.phys_page) begin
            $error("phys_page: expected %h, got %h", want.phys_page, rsp.phys_page);
            mismatches++;
          end
          if (rsp.out_offset !== want.offset) begin
            $error("out_offset: expected %h, got %h", want.offset, rsp.out_offset);
            mismatches++;
          end
          if (rsp.line_used !== want.line) begin
            $error("line_used: expected %0d, got %0d", want.line, rsp.line_used);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_answers.push_back(predict_lookup(req.command, req.virtual_page,
                                                  req.byte_offset, req.fill_phys_page));
    end
    outstanding = expected_answers.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for fully_assoc_tlb_lru_unit: drives directed and random requests
// with random gaps and response stalls, and reports the checker's verdict.
// Depends on fatlb_pkg, fatlb_req_if, fatlb_rsp_if and fatlb_lookup_checker.
module tb_top;
  import fatlb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 1600;
  localparam int POOL_SIZE    = 192;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   ready_left = 0;
  bit   burst_mode = 1'b0;

  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  fatlb_req_if req_ch ();
  fatlb_rsp_if rsp_ch ();

  fully_assoc_tlb_lru_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fatlb_lookup_checker lookup_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Response stalls: short and long, with stretches of steady ready.
  always @(posedge clk) begin : sink_pace
    int roll;
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        rsp_ch.ready <= 1'b1;
        ready_left <= $urandom_range(0, 6);
      end else if (roll < 65) begin
        rsp_ch.ready <= 1'b1;
        ready_left <= $urandom_range(40, 150);
      end else if (roll < 95) begin
        rsp_ch.ready <= 1'b0;
        ready_left <= $urandom_range(0, 3);
      end else begin
        rsp_ch.ready <= 1'b0;
        ready_left <= $urandom_range(15, 60);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the request until transfer, then optionally drop valid for a gap.
  task automatic issue_request(logic [CMD_W-1:0] command, logic [TAG_W-1:0] vpage,
                               logic [OFFSET_W-1:0] offset, logic [PAGE_W-1:0] fill);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.command <= command;
    req_ch.virtual_page <= vpage;
    req_ch.byte_offset <= offset;
    req_ch.fill_phys_page <= fill;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int roll;
    logic [TAG_W-1:0] vpage;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TRANSLATE;
    req_ch.virtual_page = '0;
    req_ch.byte_offset = '0;
    req_ch.fill_phys_page = '0;
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = {4'($urandom_range(0, 15)), 32'($urandom())};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    issue_request(CMD_TRANSLATE, '0, '0, '0);
    issue_request(CMD_RESERVED, '1, '1, '1);
    issue_request(CMD_REFILL, '1, '1, '1);
    issue_request(CMD_TRANSLATE, '1, '1, '0);
    issue_request(CMD_TRANSLATE, '1, '0, '1);
    issue_request(CMD_REFILL, '0, '0, '0);
    issue_request(CMD_TRANSLATE, '0, 12'h5a5, '0);
    issue_request(CMD_REFILL, 36'h123456789, 12'h001, 32'ha5a5a5a5);
    issue_request(CMD_REFILL, 36'h123456789, 12'h002, 32'h5a5a5a5a);
    issue_request(CMD_TRANSLATE, 36'h123456789, 12'h003, '0);
    issue_request(CMD_RESERVED, 36'h123456789, 12'h004, '0);
    issue_request(CMD_FLUSH, 36'h123456789, '1, '1);
    issue_request(CMD_TRANSLATE, '1, '1, '0);
    issue_request(CMD_TRANSLATE, '0, '0, '0);
    issue_request(CMD_TRANSLATE, 36'h123456789, 12'h800, '0);
    issue_request(CMD_REFILL, 36'h800000000, 12'h800, 32'h80000000);
    issue_request(CMD_TRANSLATE, 36'h800000000, 12'h7ff, '0);
    issue_request(CMD_TRANSLATE, 36'h7ffffffff, 12'hfff, '0);
    issue_request(CMD_FLUSH, '0, '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 999);
      vpage = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 550)
        issue_request(CMD_TRANSLATE, vpage, 12'($urandom_range(0, 4095)), 32'($urandom()));
      else if (roll < 620)
        issue_request(CMD_TRANSLATE, {4'($urandom_range(0, 15)), 32'($urandom())},
                      12'($urandom_range(0, 4095)), 32'($urandom()));
      else if (roll < 985 || i < RANDOM_ITEMS / 2)
        issue_request(CMD_REFILL, vpage, 12'($urandom_range(0, 4095)), 32'($urandom()));
      else if (roll < 993)
        issue_request(CMD_RESERVED, vpage, 12'($urandom_range(0, 4095)), 32'($urandom()));
      else
        issue_request(CMD_FLUSH, vpage, 12'($urandom_range(0, 4095)), 32'($urandom()));
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fatlb_pkg.sv
hdl/fatlb_req_if.sv
hdl/fatlb_rsp_if.sv
hdl/fatlb_cell.sv
hdl/fatlb_pick.sv
hdl/fully_assoc_tlb_lru_unit.sv
sim/fatlb_lookup_checker.sv
sim/tb_top.sv
